[hw/rtl/gbct_pkg.sv]
// ----------------------------------------------------------------------------
// gbct_pkg: shared types and constants of the green blob centroid tracker
// Holds the payload structs, the configuration set and the frame snapshot.
// ----------------------------------------------------------------------------
package gbct_pkg;

  localparam int unsigned MAX_WIDTH  = 2048;
  localparam int unsigned MAX_HEIGHT = 2048;
  localparam int unsigned POS_W      = 11;
  localparam int unsigned CNT_W      = 23;
  localparam int unsigned SUM_W      = 33;
  localparam int unsigned DIVIDEND_W = SUM_W + 4;
  localparam int unsigned CQ_W       = 15;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 23;

  localparam logic [CFG_IDX_W-1:0] REG_COLS_USED    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_USED    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PIXELS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_BRIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DELTA    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HUE_LOW      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HUE_HIGH     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SAT      = 3'd7;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic [31:0]      frame_number;
    logic             found;
    logic [CNT_W-1:0] pixel_total;
    logic [CQ_W-1:0]  center_x_q4;
    logic [CQ_W-1:0]  center_y_q4;
    logic [10:0]      box_left;
    logic [10:0]      box_top;
    logic [11:0]      box_width;
    logic [11:0]      box_height;
  } res_t;

  typedef struct packed {
    logic [11:0]      cols_used;
    logic [11:0]      rows_used;
    logic [CNT_W-1:0] min_pixels;
    logic [7:0]       min_brightness;
    logic [7:0]       min_delta;
    logic [7:0]       hue_low;
    logic [7:0]       hue_high;
    logic [6:0]       min_saturation_pct;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [SUM_W-1:0] sum_x;
    logic [SUM_W-1:0] sum_y;
    logic [POS_W-1:0] left;
    logic [POS_W-1:0] right;
    logic [POS_W-1:0] top;
    logic [POS_W-1:0] bottom;
  } snap_t;

endpackage

[hw/rtl/gbct_fifo.sv]
// ----------------------------------------------------------------------------
// gbct_fifo: frame snapshot queue
// Short register queue between the pixel front end and the centroid back end.
// ----------------------------------------------------------------------------
module gbct_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  gbct_pkg::snap_t               push_data_i,
  input  logic                          pop_i,
  output logic                          pop_valid_o,
  output gbct_pkg::snap_t               pop_data_o,
  output logic [gbct_pkg::FIFO_AW:0]    count_o
);

  gbct_pkg::snap_t                mem_q [gbct_pkg::FIFO_DEPTH];
  logic [gbct_pkg::FIFO_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [gbct_pkg::FIFO_AW:0]     cnt_q, cnt_d;
  logic                           do_pop;

  assign do_pop      = pop_i && (cnt_q != '0);
  assign pop_valid_o = (cnt_q != '0);
  assign pop_data_o  = mem_q[rd_ptr_q];
  assign count_o     = cnt_q;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[hw/rtl/gbct_front.sv]
// ----------------------------------------------------------------------------
// gbct_front: pixel front end
// Tracks raster position, classifies pixels as green and accumulates frame
// statistics; pushes one snapshot per finished frame into the queue.
// ----------------------------------------------------------------------------
module gbct_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gbct_pkg::cfg_t              cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  gbct_pkg::pix_t              in_data_i,
  input  logic [gbct_pkg::FIFO_AW:0]  fifo_count_i,
  output logic                        push_o,
  output gbct_pkg::snap_t             push_data_o
);

  localparam int unsigned PW = gbct_pkg::POS_W;

  logic          accept;
  logic [PW-1:0] col_q, row_q, last_col, last_row;
  logic          row_end, frame_end;

  // stage A
  logic          va_q, fea_q, prea_q;
  logic [PW-1:0] xa_q, ya_q;
  logic [7:0]    hia_q, spa_q;
  logic signed [9:0] na_q;

  // stage B
  logic          vb_q, feb_q, gb_q;
  logic [PW-1:0] xb_q, yb_q;

  // accumulators
  logic [gbct_pkg::CNT_W-1:0] cnt_q, cnt_n;
  logic [gbct_pkg::SUM_W-1:0] sx_q, sy_q, sx_n, sy_n;
  logic [PW-1:0] left_q, right_q, top_q, bot_q;
  logic [PW-1:0] left_n, right_n, top_n, bot_n;

  logic [7:0] hi, lo;
  logic [2:0] pend;

  always_comb begin
    if (cfg_i.cols_used == 12'd0) begin
      last_col = '0;
    end else if (cfg_i.cols_used > 12'(gbct_pkg::MAX_WIDTH)) begin
      last_col = PW'(gbct_pkg::MAX_WIDTH - 1);
    end else begin
      last_col = PW'(cfg_i.cols_used - 12'd1);
    end
    if (cfg_i.rows_used == 12'd0) begin
      last_row = '0;
    end else if (cfg_i.rows_used > 12'(gbct_pkg::MAX_HEIGHT)) begin
      last_row = PW'(gbct_pkg::MAX_HEIGHT - 1);
    end else begin
      last_row = PW'(cfg_i.rows_used - 12'd1);
    end
  end

  assign row_end   = (col_q >= last_col);
  assign frame_end = row_end && (row_q >= last_row);

  // hold off input while queued plus in-flight frame ends could overflow
  assign pend       = 3'(va_q && fea_q) + 3'(vb_q && feb_q);
  assign in_ready_o = (3'(fifo_count_i) + pend) < 3'(gbct_pkg::FIFO_DEPTH);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    hi = in_data_i.red;
    lo = in_data_i.red;
    if (in_data_i.green > hi) hi = in_data_i.green;
    if (in_data_i.blue > hi)  hi = in_data_i.blue;
    if (in_data_i.green < lo) lo = in_data_i.green;
    if (in_data_i.blue < lo)  lo = in_data_i.blue;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      va_q  <= 1'b0;
      vb_q  <= 1'b0;
    end else begin
      va_q <= accept;
      vb_q <= va_q;
      if (accept) begin
        if (!row_end) begin
          col_q <= col_q + 1'b1;
        end else begin
          col_q <= '0;
          row_q <= frame_end ? '0 : row_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      xa_q   <= col_q;
      ya_q   <= row_q;
      fea_q  <= frame_end;
      hia_q  <= hi;
      spa_q  <= hi - lo;
      na_q   <= $signed({2'b00, in_data_i.blue}) - $signed({2'b00, in_data_i.red});
      prea_q <= (hi >= cfg_i.min_brightness) && ((hi - lo) >= cfg_i.min_delta) &&
                (in_data_i.green == hi) && (hi != lo);
    end
  end

  // hue window tested by cross-multiplication instead of division
  logic signed [9:0]  lo_d, hi_d, s10, m10;
  logic signed [19:0] p1, p2, p3, p4, m20;
  logic               neg, ge_low, le_high, sat_ok;

  always_comb begin
    lo_d   = $signed({2'b00, cfg_i.hue_low}) - 10'sd120;
    hi_d   = $signed({2'b00, cfg_i.hue_high}) - 10'sd120;
    s10    = $signed({2'b00, spa_q});
    neg    = na_q[9];
    m10    = neg ? -na_q : na_q;
    // scale the channel difference by the 60 degree sector width
    m20    = 20'sd60 * 20'(m10);
    p1     = lo_d * s10;
    p2     = (10'sd1 - lo_d) * s10;
    p3     = (hi_d + 10'sd1) * s10;
    p4     = (-hi_d) * s10;
    if (!neg) begin
      ge_low  = (lo_d <= 10'sd0) || (m20 >= p1);
      le_high = (hi_d >= 10'sd0) && (m20 < p3);
    end else begin
      ge_low  = (lo_d <= 10'sd0) && (m20 < p2);
      le_high = (hi_d >= 10'sd0) || (m20 >= p4);
    end
    sat_ok = (15'(spa_q) * 15'd100) >= (15'(cfg_i.min_saturation_pct) * 15'(hia_q));
  end

  always_ff @(posedge clk_i) begin
    if (va_q) begin
      xb_q  <= xa_q;
      yb_q  <= ya_q;
      feb_q <= fea_q;
      gb_q  <= prea_q && ge_low && le_high && sat_ok;
    end
  end

  always_comb begin
    cnt_n   = cnt_q;
    sx_n    = sx_q;
    sy_n    = sy_q;
    left_n  = left_q;
    right_n = right_q;
    top_n   = top_q;
    bot_n   = bot_q;
    if (gb_q) begin
      if (cnt_q == '0 || xb_q < left_q)  left_n  = xb_q;
      if (cnt_q == '0 || xb_q > right_q) right_n = xb_q;
      if (cnt_q == '0 || yb_q < top_q)   top_n   = yb_q;
      if (cnt_q == '0 || yb_q > bot_q)   bot_n   = yb_q;
      cnt_n = cnt_q + 1'b1;
      sx_n  = sx_q + gbct_pkg::SUM_W'(xb_q);
      sy_n  = sy_q + gbct_pkg::SUM_W'(yb_q);
    end
  end

  assign push_o = vb_q && feb_q;

  always_comb begin
    push_data_o.count  = cnt_n;
    push_data_o.sum_x  = sx_n;
    push_data_o.sum_y  = sy_n;
    push_data_o.left   = left_n;
    push_data_o.right  = right_n;
    push_data_o.top    = top_n;
    push_data_o.bottom = bot_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      sx_q    <= '0;
      sy_q    <= '0;
      left_q  <= '1;
      right_q <= '0;
      top_q   <= '1;
      bot_q   <= '0;
    end else if (vb_q) begin
      if (feb_q) begin
        // clear for the next frame
        cnt_q   <= '0;
        sx_q    <= '0;
        sy_q    <= '0;
        left_q  <= '1;
        right_q <= '0;
        top_q   <= '1;
        bot_q   <= '0;
      end else begin
        cnt_q   <= cnt_n;
        sx_q    <= sx_n;
        sy_q    <= sy_n;
        left_q  <= left_n;
        right_q <= right_n;
        top_q   <= top_n;
        bot_q   <= bot_n;
      end
    end
  end

endmodule

[hw/rtl/gbct_div.sv]
// ----------------------------------------------------------------------------
// gbct_div: restoring divider
// One quotient bit per cycle; returns the low bits of the centroid quotient.
// ----------------------------------------------------------------------------
module gbct_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [gbct_pkg::DIVIDEND_W-1:0]   dividend_i,
  input  logic [gbct_pkg::CNT_W-1:0]        divisor_i,
  output logic                              done_o,
  output logic [gbct_pkg::CQ_W-1:0]         quotient_o
);

  localparam int unsigned DW = gbct_pkg::DIVIDEND_W;
  localparam int unsigned VW = gbct_pkg::CNT_W;

  logic [DW-1:0] dq_q;
  logic [VW-1:0] rem_q, den_q;
  logic [5:0]    step_q;
  logic          busy_q, done_q;
  logic [VW:0]   trial;
  logic          qbit;

  assign trial      = {rem_q, dq_q[DW-1]};
  assign qbit       = (trial >= {1'b0, den_q});
  assign done_o     = done_q;
  assign quotient_o = dq_q[gbct_pkg::CQ_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == 6'(DW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= qbit ? VW'(trial - {1'b0, den_q}) : trial[VW-1:0];
      dq_q  <= {dq_q[DW-2:0], qbit};
    end
  end

endmodule

[hw/rtl/gbct_back.sv]
// ----------------------------------------------------------------------------
// gbct_back: centroid back end
// Pops frame snapshots, divides the sums by the count for found frames and drives results.
// ----------------------------------------------------------------------------
module gbct_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gbct_pkg::cfg_t   cfg_i,
  input  logic             pop_valid_i,
  input  gbct_pkg::snap_t  pop_data_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output gbct_pkg::res_t   out_data_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]      state_q, state_d;
  gbct_pkg::snap_t snap_q;
  logic            found_q, use_q;
  logic [31:0]     frame_q;
  logic            out_valid_q;
  gbct_pkg::res_t  out_q;
  logic            start, done_x, done_y, load_out, found, use_div;
  logic [gbct_pkg::CQ_W-1:0] qx, qy;

  assign found   = (pop_data_i.count >= cfg_i.min_pixels);
  assign use_div = found && (pop_data_i.count != '0);
  assign pop_o   = (state_q == ST_IDLE) && pop_valid_i;
  assign start   = pop_o && use_div;
  assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  gbct_div u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .dividend_i ({pop_data_i.sum_x, 4'b0000}),
    .divisor_i  (pop_data_i.count),
    .done_o     (done_x),
    .quotient_o (qx)
  );

  gbct_div u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .dividend_i ({pop_data_i.sum_y, 4'b0000}),
    .divisor_i  (pop_data_i.count),
    .done_o     (done_y),
    .quotient_o (qy)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pop_o) state_d = use_div ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        if (done_x && done_y) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      frame_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
        frame_q     <= frame_q + 32'd1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      snap_q  <= pop_data_i;
      found_q <= found;
      use_q   <= use_div;
    end
    if (load_out) begin
      out_q.frame_number <= frame_q;
      out_q.found        <= found_q;
      out_q.pixel_total  <= snap_q.count;
      out_q.center_x_q4  <= use_q ? qx : '0;
      out_q.center_y_q4  <= use_q ? qy : '0;
      out_q.box_left     <= use_q ? snap_q.left : '0;
      out_q.box_top      <= use_q ? snap_q.top : '0;
      out_q.box_width    <= use_q ? 12'(snap_q.right - snap_q.left) + 12'd1 : '0;
      out_q.box_height   <= use_q ? 12'(snap_q.bottom - snap_q.top) + 12'd1 : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[hw/rtl/green_blob_centroid_tracker_unit.sv]
// ----------------------------------------------------------------------------
// green_blob_centroid_tracker_unit: green blob centroid and box tracker
// Classifies RGB pixels in raster order and reports one result per frame.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle; input stalls only while queued and in-flight
//   frame ends fill the four-entry queue (frames shorter than a division, or
//   results held at the output). Division uses the 37-step restoring dividers;
//   frames that need no division skip them.
// Reset: asynchronous, active low; configuration returns to defaults and all
//   counters and accumulators clear.
// ----------------------------------------------------------------------------
module green_blob_centroid_tracker_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [gbct_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [gbct_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  gbct_pkg::pix_t                      in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output gbct_pkg::res_t                      out_data_o
);

  gbct_pkg::cfg_t  cfg_q;
  logic            push, pop, pop_valid;
  gbct_pkg::snap_t push_data, pop_data;
  logic [gbct_pkg::FIFO_AW:0] fifo_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cols_used          <= 12'd640;
      cfg_q.rows_used          <= 12'd480;
      cfg_q.min_pixels         <= 23'd80;
      cfg_q.min_brightness     <= 8'd50;
      cfg_q.min_delta          <= 8'd30;
      cfg_q.hue_low            <= 8'd60;
      cfg_q.hue_high           <= 8'd170;
      cfg_q.min_saturation_pct <= 7'd35;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gbct_pkg::REG_COLS_USED:    cfg_q.cols_used          <= cfg_data_i[11:0];
        gbct_pkg::REG_ROWS_USED:    cfg_q.rows_used          <= cfg_data_i[11:0];
        gbct_pkg::REG_MIN_PIXELS:   cfg_q.min_pixels         <= cfg_data_i;
        gbct_pkg::REG_MIN_BRIGHT:   cfg_q.min_brightness     <= cfg_data_i[7:0];
        gbct_pkg::REG_MIN_DELTA:    cfg_q.min_delta          <= cfg_data_i[7:0];
        gbct_pkg::REG_HUE_LOW:      cfg_q.hue_low            <= cfg_data_i[7:0];
        gbct_pkg::REG_HUE_HIGH:     cfg_q.hue_high           <= cfg_data_i[7:0];
        gbct_pkg::REG_MIN_SAT:      cfg_q.min_saturation_pct <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  gbct_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .fifo_count_i (fifo_count),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  gbct_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_valid_o (pop_valid),
    .pop_data_o  (pop_data),
    .count_o     (fifo_count)
  );

  gbct_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
